// File: sv/stn_pkg.sv
// ----------------------------------------------------------------------------
// stn_pkg
// Types, constants and register map shared by the timestamp normalizer.
// ----------------------------------------------------------------------------
package stn_pkg;

    localparam int STAMP_W    = 63;
    localparam int SEQ_W      = 8;
    localparam int INTERVAL_W = 30;
    localparam int SKEW_W     = 32;
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    localparam logic [SKEW_W-1:0] PAST_SKEW_RESET   = 32'd100_000_000;
    localparam logic [SKEW_W-1:0] FUTURE_SKEW_RESET = 32'd5_000_000;

    localparam logic [1:0] REG_INTERVAL    = 2'd0;
    localparam logic [1:0] REG_PAST_SKEW   = 2'd1;
    localparam logic [1:0] REG_FUTURE_SKEW = 2'd2;

    localparam logic FUNC_NORMALIZE = 1'b0;
    localparam logic FUNC_CLEAR     = 1'b1;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic [SKEW_W-1:0]     past_skew;
        logic [SKEW_W-1:0]     future_skew;
    } cfg_t;

    typedef struct packed {
        logic               func;
        logic [STAMP_W-1:0] report_stamp;
        logic [STAMP_W-1:0] host_stamp;
        logic [SEQ_W-1:0]   seq_num;
    } item_t;

    typedef struct packed {
        logic               valid;
        logic [SEQ_W-1:0]   seq;
        logic [STAMP_W-1:0] stamp;
    } hist_t;

    typedef struct packed {
        logic [STAMP_W-1:0] out_stamp;
        logic               domain_reset;
        logic               is_duplicate;
        logic               seq_gap;
        logic               nonmono_repaired;
        logic               gap_to_interval;
        logic               dup_to_interval;
        logic               back_to_interval;
        logic               clamped_to_host;
        logic               bounded_to_plus_one;
    } result_t;

endpackage

// File: sv/stn_apb_regs.sv
// ----------------------------------------------------------------------------
// stn_apb_regs
// APB register file holding the interval and the skew limits.
// ----------------------------------------------------------------------------
module stn_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [stn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [stn_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output stn_pkg::cfg_t                  cfg
);
    import stn_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_INTERVAL:    cfg_next.interval    = pwdata[INTERVAL_W-1:0];
                REG_PAST_SKEW:   cfg_next.past_skew   = pwdata[SKEW_W-1:0];
                REG_FUTURE_SKEW: cfg_next.future_skew = pwdata[SKEW_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interval    <= '0;
            cfg_reg.past_skew   <= PAST_SKEW_RESET;
            cfg_reg.future_skew <= FUTURE_SKEW_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_INTERVAL:
                prdata = {{(APB_DATA_W-INTERVAL_W){1'b0}}, cfg_reg.interval};
            REG_PAST_SKEW:   prdata = cfg_reg.past_skew;
            REG_FUTURE_SKEW: prdata = cfg_reg.future_skew;
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: sv/stn_repair.sv
// ----------------------------------------------------------------------------
// stn_repair
// Skew check, duplicate detection and monotonic repair of one report.
// ----------------------------------------------------------------------------
module stn_repair (
    input  stn_pkg::cfg_t    cfg,
    input  stn_pkg::item_t   item,
    input  stn_pkg::hist_t   hist,
    output stn_pkg::result_t res,
    output stn_pkg::hist_t   hist_next
);
    import stn_pkg::*;

    localparam int PROD_W = INTERVAL_W + SEQ_W;

    logic               host_ge;
    logic [STAMP_W-1:0] past_diff;
    logic [STAMP_W-1:0] future_diff;
    logic               skew_reset;
    logic [STAMP_W-1:0] st;
    logic               dup;
    logic [SEQ_W-1:0]   delta;
    logic [PROD_W-1:0]  prod;
    logic [STAMP_W:0]   cand;
    logic [STAMP_W-1:0] plus_one;
    logic               interval_ok;

    always_comb
    begin
        host_ge     = item.host_stamp >= item.report_stamp;
        past_diff   = item.host_stamp - item.report_stamp;
        future_diff = item.report_stamp - item.host_stamp;
        if (host_ge)
            skew_reset = past_diff > {{(STAMP_W-SKEW_W){1'b0}}, cfg.past_skew};
        else
            skew_reset = future_diff > {{(STAMP_W-SKEW_W){1'b0}}, cfg.future_skew};
        st = skew_reset ? item.host_stamp : item.report_stamp;

        dup         = hist.valid && (item.seq_num == hist.seq) && (st == hist.stamp);
        delta       = item.seq_num - hist.seq;
        prod        = PROD_W'(cfg.interval) * PROD_W'(delta);
        cand        = {1'b0, hist.stamp} + (STAMP_W+1)'(prod);
        plus_one    = (hist.stamp == STAMP_MAX) ? STAMP_MAX : hist.stamp + 1'b1;
        interval_ok = (delta != '0) && (cfg.interval != '0);

        res              = '0;
        res.domain_reset = skew_reset;
        res.out_stamp    = st;

        if (dup)
        begin
            res.is_duplicate = 1'b1;
        end
        else if (hist.valid)
        begin
            res.seq_gap = item.seq_num != (hist.seq + 1'b1);
            if (st <= hist.stamp)
            begin
                res.nonmono_repaired = 1'b1;
                if (interval_ok)
                begin
                    res.gap_to_interval  = delta > SEQ_W'(1);
                    res.dup_to_interval  = (delta == SEQ_W'(1)) && (st == hist.stamp);
                    res.back_to_interval = (delta == SEQ_W'(1)) && (st < hist.stamp);
                    if (cand <= {1'b0, item.host_stamp})
                    begin
                        res.out_stamp = cand[STAMP_W-1:0];
                    end
                    else if (item.host_stamp > hist.stamp)
                    begin
                        res.out_stamp       = item.host_stamp;
                        res.clamped_to_host = 1'b1;
                    end
                    else
                    begin
                        res.out_stamp           = plus_one;
                        res.bounded_to_plus_one = 1'b1;
                    end
                end
                else
                begin
                    res.out_stamp = plus_one;
                end
            end
        end

        if (item.func == FUNC_CLEAR)
        begin
            hist_next = '0;
        end
        else if (dup)
        begin
            hist_next = hist;
        end
        else
        begin
            hist_next.valid = 1'b1;
            hist_next.seq   = item.seq_num;
            hist_next.stamp = res.out_stamp;
        end
    end

endmodule

// File: sv/sensor_timestamp_normalizer.sv
// ----------------------------------------------------------------------------
// sensor_timestamp_normalizer
// Repairs sensor report timestamps against host time and report history.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                      payload
//  input     in         in_valid / in_stall            func, report_stamp, host_stamp, seq_num
//  output    out        out_valid / out_stall          out_stamp and nine status flags
//  config    in         psel, penable, pwrite, pready  paddr[3:0], pwdata, prdata
//
// A word passes an input register and then a result register before its result
// is offered; one word is accepted every cycle while the output does not stall.
// The history registers update as a word leaves the input register.
// A clear word empties the history and produces no result word.
// Reset restores the default register values and empties the history.
// A stall on the output holds the result and backs up into the input register.
// ----------------------------------------------------------------------------
module sensor_timestamp_normalizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stn_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [stn_pkg::APB_DATA_W-1:0] pwdata,
    output logic [stn_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           func,
    input  logic [stn_pkg::STAMP_W-1:0]    report_stamp,
    input  logic [stn_pkg::STAMP_W-1:0]    host_stamp,
    input  logic [stn_pkg::SEQ_W-1:0]      seq_num,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [stn_pkg::STAMP_W-1:0]    out_stamp,
    output logic                           domain_reset,
    output logic                           is_duplicate,
    output logic                           seq_gap,
    output logic                           nonmono_repaired,
    output logic                           gap_to_interval,
    output logic                           dup_to_interval,
    output logic                           back_to_interval,
    output logic                           clamped_to_host,
    output logic                           bounded_to_plus_one
);
    import stn_pkg::*;

    cfg_t    cfg;
    logic    s1_valid_reg;
    logic    s1_valid_next;
    item_t   s1_item_reg;
    item_t   s1_item_next;
    hist_t   hist_reg;
    hist_t   hist_next;
    hist_t   hist_calc;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_res_reg;
    result_t out_res_next;
    result_t res_calc;
    logic    advance;
    logic    in_accept;
    logic    fire;

    stn_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stn_repair u_repair (
        .cfg       (cfg),
        .item      (s1_item_reg),
        .hist      (hist_reg),
        .res       (res_calc),
        .hist_next (hist_calc)
    );

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign fire      = s1_valid_reg && advance;

    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        s1_item_next = s1_item_reg;
        if (in_accept)
        begin
            s1_item_next.func         = func;
            s1_item_next.report_stamp = report_stamp;
            s1_item_next.host_stamp   = host_stamp;
            s1_item_next.seq_num      = seq_num;
        end

        hist_next = fire ? hist_calc : hist_reg;

        if (advance)
            out_valid_next = fire && (s1_item_reg.func == FUNC_NORMALIZE);
        else
            out_valid_next = out_valid_reg;

        out_res_next = (fire && (s1_item_reg.func == FUNC_NORMALIZE)) ? res_calc : out_res_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            hist_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            hist_reg      <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= s1_item_next;
        out_res_reg <= out_res_next;
    end

    assign out_valid           = out_valid_reg;
    assign out_stamp           = out_res_reg.out_stamp;
    assign domain_reset        = out_res_reg.domain_reset;
    assign is_duplicate        = out_res_reg.is_duplicate;
    assign seq_gap             = out_res_reg.seq_gap;
    assign nonmono_repaired    = out_res_reg.nonmono_repaired;
    assign gap_to_interval     = out_res_reg.gap_to_interval;
    assign dup_to_interval     = out_res_reg.dup_to_interval;
    assign back_to_interval    = out_res_reg.back_to_interval;
    assign clamped_to_host     = out_res_reg.clamped_to_host;
    assign bounded_to_plus_one = out_res_reg.bounded_to_plus_one;

endmodule

// File: dv/sensor_timestamp_normalizer_tb.sv
// ----------------------------------------------------------------------------
// sensor_timestamp_normalizer_tb
// Self-checking bench for the timestamp normalizer. Words are driven from a
// backlog with random gaps, results are drained with random stalls and long
// hold-offs, and every accepted result is compared field by field with a
// bench-side model of the skew test, duplicate test and stamp repair. The run
// steps through several register settings, including the extremes, written
// over the APB port while the block is idle and read back afterwards.
// ----------------------------------------------------------------------------
module sensor_timestamp_normalizer_tb;
    import stn_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int PHASE_WORDS  = 320;
    localparam int PHASES       = 6;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  func         = FUNC_NORMALIZE;
    logic [STAMP_W-1:0]    report_stamp = '0;
    logic [STAMP_W-1:0]    host_stamp   = '0;
    logic [SEQ_W-1:0]      seq_num      = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic [STAMP_W-1:0]    out_stamp;
    logic                  domain_reset;
    logic                  is_duplicate;
    logic                  seq_gap;
    logic                  nonmono_repaired;
    logic                  gap_to_interval;
    logic                  dup_to_interval;
    logic                  back_to_interval;
    logic                  clamped_to_host;
    logic                  bounded_to_plus_one;

    sensor_timestamp_normalizer dut (.*);

    always #1 clk = ~clk;

    item_t   word_backlog[$];
    result_t due_results[$];
    cfg_t    cfg;
    hist_t   hist;

    int mismatches      = 0;
    int results_checked = 0;
    int words_taken     = 0;
    int clears_taken    = 0;
    int settings_used   = 0;
    int quiet_cycles    = 0;
    int n_resets        = 0;
    int n_dups          = 0;
    int n_clamps        = 0;
    int n_bounds        = 0;
    int n_interval      = 0;

    logic [63:0]        cur_t;
    logic [SEQ_W-1:0]   cur_seq;
    logic [STAMP_W-1:0] last_rs;
    logic [STAMP_W-1:0] last_hs;

    function automatic logic [STAMP_W-1:0] bump_stamp(input logic [STAMP_W-1:0] v);
        return (v == STAMP_MAX) ? STAMP_MAX : v + 1'b1;
    endfunction

    function automatic logic [STAMP_W-1:0] to_stamp(input logic [63:0] v);
        return v[STAMP_W-1:0];
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[STAMP_W-1:0];
    endfunction

    function automatic bit normalize_word(input item_t w, output result_t r);
        logic [STAMP_W-1:0] st;
        logic [63:0]        cand;
        logic [SEQ_W-1:0]   delta;
        logic [SEQ_W-1:0]   next_seq;
        r = '0;
        if (w.func == FUNC_CLEAR)
        begin
            hist = '0;
            return 1'b0;
        end
        st = w.report_stamp;
        if (w.host_stamp >= w.report_stamp)
        begin
            if (w.host_stamp - w.report_stamp > {31'b0, cfg.past_skew})
            begin
                st = w.host_stamp;
                r.domain_reset = 1'b1;
            end
        end
        else if (w.report_stamp - w.host_stamp > {31'b0, cfg.future_skew})
        begin
            st = w.host_stamp;
            r.domain_reset = 1'b1;
        end
        if (hist.valid)
        begin
            if (w.seq_num == hist.seq && st == hist.stamp)
            begin
                r.out_stamp = st;
                r.is_duplicate = 1'b1;
                return 1'b1;
            end
            delta = w.seq_num - hist.seq;
            next_seq = hist.seq + 1'b1;
            r.seq_gap = (w.seq_num != next_seq);
            if (st <= hist.stamp)
            begin
                r.nonmono_repaired = 1'b1;
                if (delta != '0 && cfg.interval != '0)
                begin
                    cand = {1'b0, hist.stamp} + {34'b0, cfg.interval} * {56'b0, delta};
                    r.gap_to_interval = (delta > SEQ_W'(1));
                    r.dup_to_interval = !r.gap_to_interval && st == hist.stamp;
                    r.back_to_interval = !r.gap_to_interval && st < hist.stamp;
                    if (cand <= {1'b0, w.host_stamp})
                    begin
                        st = cand[STAMP_W-1:0];
                    end
                    else if (w.host_stamp > hist.stamp)
                    begin
                        st = w.host_stamp;
                        r.clamped_to_host = 1'b1;
                    end
                    else
                    begin
                        st = bump_stamp(hist.stamp);
                        r.bounded_to_plus_one = 1'b1;
                    end
                end
                else
                begin
                    st = bump_stamp(hist.stamp);
                end
            end
        end
        hist.valid = 1'b1;
        hist.seq = w.seq_num;
        hist.stamp = st;
        r.out_stamp = st;
        return 1'b1;
    endfunction

    task automatic check_field(input string name, input logic [STAMP_W-1:0] want,
                               input logic [STAMP_W-1:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("result %0d, %s: expected %0h, actual %0h",
                         results_checked, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : word_driver
        item_t w;
        bit    rest;
        int    sent_words;
        if (rst_n && (!in_valid || !in_stall))
        begin
            rest = ($urandom_range(0, 99) < 25) && !(sent_words >= 700 && sent_words < 1000);
            if (word_backlog.size() != 0 && !rest)
            begin
                w = word_backlog.pop_front();
                func <= w.func;
                report_stamp <= w.report_stamp;
                host_stamp <= w.host_stamp;
                seq_num <= w.seq_num;
                in_valid <= 1'b1;
                sent_words++;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_sink
        int drained;
        int hold_left;
        int next_hold;
        if (next_hold == 0)
            next_hold = 300;
        if (out_valid && !out_stall)
            drained++;
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (drained >= next_hold)
        begin
            hold_left = HOLD_CYCLES;
            next_hold += 900;
            out_stall <= 1'b1;
        end
        else if (drained >= 600 && drained < 900)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < 25);
        end
    end

    always @(posedge clk)
    begin : scoreboard
        result_t seen;
        result_t want;
        result_t fresh;
        bit      took_in;
        bit      took_out;
        took_in = rst_n && in_valid && !in_stall;
        took_out = rst_n && out_valid && !out_stall;
        if (took_out)
        begin
            seen.out_stamp = out_stamp;
            seen.domain_reset = domain_reset;
            seen.is_duplicate = is_duplicate;
            seen.seq_gap = seq_gap;
            seen.nonmono_repaired = nonmono_repaired;
            seen.gap_to_interval = gap_to_interval;
            seen.dup_to_interval = dup_to_interval;
            seen.back_to_interval = back_to_interval;
            seen.clamped_to_host = clamped_to_host;
            seen.bounded_to_plus_one = bounded_to_plus_one;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result word with nothing outstanding: stamp %0h", out_stamp);
            end
            else
            begin
                want = due_results.pop_front();
                check_field("out_stamp", want.out_stamp, seen.out_stamp);
                check_field("domain_reset", want.domain_reset, seen.domain_reset);
                check_field("is_duplicate", want.is_duplicate, seen.is_duplicate);
                check_field("seq_gap", want.seq_gap, seen.seq_gap);
                check_field("nonmono_repaired", want.nonmono_repaired, seen.nonmono_repaired);
                check_field("gap_to_interval", want.gap_to_interval, seen.gap_to_interval);
                check_field("dup_to_interval", want.dup_to_interval, seen.dup_to_interval);
                check_field("back_to_interval", want.back_to_interval, seen.back_to_interval);
                check_field("clamped_to_host", want.clamped_to_host, seen.clamped_to_host);
                check_field("bounded_to_plus_one", want.bounded_to_plus_one,
                            seen.bounded_to_plus_one);
            end
            results_checked++;
        end
        if (took_in)
        begin
            words_taken++;
            if (func == FUNC_CLEAR)
                clears_taken++;
            if (normalize_word({func, report_stamp, host_stamp, seq_num}, fresh))
            begin
                due_results.push_back(fresh);
                n_resets += int'(fresh.domain_reset);
                n_dups += int'(fresh.is_duplicate);
                n_clamps += int'(fresh.clamped_to_host);
                n_bounds += int'(fresh.bounded_to_plus_one);
                n_interval += int'(fresh.gap_to_interval | fresh.dup_to_interval |
                                   fresh.back_to_interval);
            end
        end
        quiet_cycles = (took_in || took_out || psel) ? 0 : quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("no handshake for %0d cycles", QUIET_LIMIT);
        $display("FAIL sensor_timestamp_normalizer");
        $finish;
    end

    task automatic apb_access(input logic [1:0] idx, input logic wr,
                              input logic [APB_DATA_W-1:0] data,
                              output logic [APB_DATA_W-1:0] rd);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic verify_register(input logic [1:0] idx, input logic [APB_DATA_W-1:0] want);
        logic [APB_DATA_W-1:0] got;
        apb_access(idx, 1'b0, '0, got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("register %0d reads %0h, expected %0h", idx, got, want);
        end
    endtask

    task automatic apply_settings(input logic [INTERVAL_W-1:0] ival,
                                  input logic [SKEW_W-1:0] past, input logic [SKEW_W-1:0] fut);
        logic [APB_DATA_W-1:0] unused;
        apb_access(REG_INTERVAL, 1'b1, {2'b00, ival}, unused);
        cfg.interval = ival;
        apb_access(REG_PAST_SKEW, 1'b1, past, unused);
        cfg.past_skew = past;
        apb_access(REG_FUTURE_SKEW, 1'b1, fut, unused);
        cfg.future_skew = fut;
        verify_register(REG_INTERVAL, {2'b00, cfg.interval});
        verify_register(REG_PAST_SKEW, cfg.past_skew);
        verify_register(REG_FUTURE_SKEW, cfg.future_skew);
        settings_used++;
        @(negedge clk);
    endtask

    task automatic put_word(input logic f, input logic [STAMP_W-1:0] rs,
                            input logic [STAMP_W-1:0] hs, input logic [SEQ_W-1:0] sq);
        item_t w;
        w.func = f;
        w.report_stamp = rs;
        w.host_stamp = hs;
        w.seq_num = sq;
        word_backlog.push_back(w);
    endtask

    // Clear words leave nothing outstanding, so an extra wait at the end covers one
    // that may still be in the pipeline.
    task automatic wait_drained();
        do @(negedge clk);
        while (word_backlog.size() != 0 || in_valid || due_results.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // Mostly a steadily advancing report stream, mixed with repeats, backward
    // and stalled stamps, sequence jumps, skewed stamps, clears and noise.
    task automatic queue_stream(input int count);
        logic [63:0]        pace;
        logic [63:0]        jit;
        logic [STAMP_W-1:0] rs;
        logic [STAMP_W-1:0] hs;
        logic [SEQ_W-1:0]   sq;
        int                 kind;
        int                 hops;
        pace = (cfg.interval == '0) ? 64'd1000 : {34'b0, cfg.interval};
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(0, 99);
            jit = 64'($urandom_range(0, pace[31:0] >> 3));
            rs = last_rs;
            hs = last_hs;
            if (kind < 55)
            begin
                cur_seq = cur_seq + 1'b1;
                cur_t = cur_t + pace + jit;
                rs = to_stamp(cur_t);
                hs = to_stamp(cur_t + 64'($urandom_range(0, 3000)));
            end
            else if (kind < 62)
            begin
                rs = last_rs;
            end
            else if (kind < 70)
            begin
                cur_seq = cur_seq + 1'b1;
                rs = ($urandom_range(0, 1) == 0) ? last_rs :
                     last_rs - STAMP_W'($urandom_range(1, 500));
                case ($urandom_range(0, 2))
                    0: hs = to_stamp({1'b0, last_rs} + (pace << 1));
                    1: hs = to_stamp({1'b0, last_rs} + (pace >> 1));
                    default: hs = last_rs - STAMP_W'($urandom_range(0, 100));
                endcase
            end
            else if (kind < 77)
            begin
                hops = $urandom_range(2, 20);
                cur_seq = cur_seq + SEQ_W'(hops);
                if ($urandom_range(0, 1) == 0)
                begin
                    rs = last_rs;
                    hs = to_stamp({1'b0, last_rs} + pace * 64'($urandom_range(1, 2 * hops)));
                    cur_t = {1'b0, last_rs} + pace * 64'(hops);
                end
                else
                begin
                    cur_t = cur_t + pace * 64'(hops);
                    rs = to_stamp(cur_t);
                    hs = to_stamp(cur_t + 64'($urandom_range(0, 3000)));
                end
            end
            else if (kind < 83)
            begin
                cur_seq = cur_seq + 1'b1;
                cur_t = cur_t + pace;
                hs = to_stamp(cur_t);
                if ($urandom_range(0, 1) == 0)
                    rs = to_stamp(cur_t - {32'b0, cfg.past_skew} - 64'd1 -
                                  64'($urandom_range(0, 1000)));
                else
                    rs = to_stamp(cur_t + {32'b0, cfg.future_skew} + 64'd1 +
                                  64'($urandom_range(0, 1000)));
            end
            else if (kind < 91)
            begin
                rs = last_rs - STAMP_W'($urandom_range(1, 1000));
            end
            sq = cur_seq;
            if (kind >= 83 && kind < 86)
            begin
                put_word(FUNC_CLEAR, rand_stamp(), rand_stamp(), SEQ_W'($urandom));
            end
            else
            begin
                if (kind >= 91)
                begin
                    rs = rand_stamp();
                    hs = rand_stamp();
                    sq = SEQ_W'($urandom);
                end
                put_word(FUNC_NORMALIZE, rs, hs, sq);
                last_rs = rs;
                last_hs = hs;
            end
        end
    endtask

    initial
    begin : stimulus
        cfg.interval = '0;
        cfg.past_skew = PAST_SKEW_RESET;
        cfg.future_skew = FUTURE_SKEW_RESET;
        hist = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        verify_register(REG_INTERVAL, {2'b00, cfg.interval});
        verify_register(REG_PAST_SKEW, cfg.past_skew);
        verify_register(REG_FUTURE_SKEW, cfg.future_skew);
        @(negedge clk);

        put_word(FUNC_NORMALIZE, 1000, 1000, 0);
        put_word(FUNC_NORMALIZE, 1000, 1000, 0);
        put_word(FUNC_NORMALIZE, 2000, 2100, 1);
        put_word(FUNC_NORMALIZE, 1500, 2200, 2);
        put_word(FUNC_NORMALIZE, 1000, 2300, 2);
        put_word(FUNC_NORMALIZE, 0, 200_000_000, 3);
        put_word(FUNC_NORMALIZE, 205_000_101, 200_000_100, 4);
        put_word(FUNC_NORMALIZE, 300_000_000, 400_000_000, 5);
        put_word(FUNC_CLEAR, STAMP_MAX, STAMP_MAX, 255);
        put_word(FUNC_NORMALIZE, STAMP_MAX, STAMP_MAX, 255);
        put_word(FUNC_NORMALIZE, STAMP_MAX, STAMP_MAX, 0);
        put_word(FUNC_NORMALIZE, 0, 0, 0);
        put_word(FUNC_CLEAR, 0, 0, 0);
        wait_drained();

        apply_settings(1000, PAST_SKEW_RESET, FUTURE_SKEW_RESET);
        put_word(FUNC_NORMALIZE, 1_000_000, 1_000_000, 10);
        put_word(FUNC_NORMALIZE, 1_000_000, 1_005_000, 11);
        put_word(FUNC_NORMALIZE, 900_000, 1_500_000, 12);
        put_word(FUNC_NORMALIZE, 1_000_000, 1_100_000, 15);
        put_word(FUNC_NORMALIZE, 1_000_000, 1_005_500, 16);
        put_word(FUNC_NORMALIZE, 1_000_000, 1_005_500, 17);
        put_word(FUNC_NORMALIZE, 2_000_000, 2_000_000, 17);
        wait_drained();

        apply_settings(1_000_000_000, 32'hFFFF_FFFF, 32'd0);
        put_word(FUNC_CLEAR, 0, 0, 0);
        put_word(FUNC_NORMALIZE, 1000, 999, 0);
        put_word(FUNC_NORMALIZE, STAMP_MAX - 10, STAMP_MAX - 10, 1);
        put_word(FUNC_NORMALIZE, STAMP_MAX - 20, STAMP_MAX, 2);
        put_word(FUNC_NORMALIZE, STAMP_MAX, STAMP_MAX, 3);
        put_word(FUNC_NORMALIZE, 5, STAMP_MAX, 200);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: apply_settings(1000, PAST_SKEW_RESET, FUTURE_SKEW_RESET);
                1: apply_settings(0, 32'd0, 32'd0);
                2: apply_settings(1_000_000_000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
                3: apply_settings(1, 32'd5000, 32'd2000);
                4: apply_settings(INTERVAL_W'($urandom_range(0, 1_000_000_000)),
                                  $urandom, $urandom);
                default: apply_settings(INTERVAL_W'($urandom_range(1, 5000)),
                                        PAST_SKEW_RESET, FUTURE_SKEW_RESET);
            endcase
            cur_t = {12'b0, 20'($urandom_range(1, 20'hFFFFF)), $urandom};
            cur_seq = SEQ_W'($urandom);
            last_rs = to_stamp(cur_t);
            last_hs = to_stamp(cur_t);
            queue_stream(PHASE_WORDS);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        $display("%0d words taken (%0d clears) under %0d register settings, %0d results checked",
                 words_taken, clears_taken, settings_used, results_checked);
        $display("seen: %0d skew resets, %0d duplicates, %0d interval repairs,",
                 n_resets, n_dups, n_interval);
        $display("      %0d host clamps, %0d plus-one bounds", n_clamps, n_bounds);
        if (mismatches == 0 && due_results.size() == 0)
            $display("PASS sensor_timestamp_normalizer");
        else
            $display("FAIL sensor_timestamp_normalizer");
        $finish;
    end

endmodule
